### design/rabs_pkg.sv
// rabs_pkg: shared constants, types and register codes of the running average
// background subtraction block; used by every module, depends on nothing
`default_nettype none
package rabs_pkg;

  localparam int unsigned IMG_WIDTH  = 640;
  localparam int unsigned IMG_HEIGHT = 480;
  localparam int unsigned CHANNELS   = 3;
  localparam int unsigned NPIX       = IMG_WIDTH * IMG_HEIGHT;
  localparam int unsigned ADDR_W     = (NPIX > 1) ? $clog2(NPIX) : 1;

  localparam int unsigned PIX_W   = 19;
  localparam int unsigned SAMP_W  = 8;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned MEAN_W  = SAMP_W + FRAC_W;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned FC_W    = 4;
  localparam int unsigned PROD_W  = MEAN_W + RATE_W;
  localparam int unsigned STORE_W = CHANNELS * MEAN_W;

  localparam logic [FC_W-1:0]   FC_MAX   = {FC_W{1'b1}};
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd30;
  localparam logic [FC_W-1:0]   WARMUP_RST    = 4'd10;
  localparam logic [RATE_W-1:0] WARM_RATE_RST = 16'd32768;
  localparam logic [RATE_W-1:0] STEADY_RST    = 16'd3;
  localparam logic [RATE_W-1:0] CLOSE_RST     = 16'd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgThreshold    = 3'd0,
    CfgWarmupFrames = 3'd1,
    CfgWarmupRate   = 3'd2,
    CfgSteadyRate   = 3'd3,
    CfgCloseRate    = 3'd4
  } cfg_idx_e;

  // control that travels alongside an item through the update stages
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              live;
    logic              hold;
    logic              fast;
    logic              first;
  } ctl_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic               vld_en;
    logic               mean_en;
    logic [ADDR_W-1:0]  addr;
    logic [STORE_W-1:0] data;
  } wr_req_t;

endpackage
`default_nettype wire

### design/rabs_pix_if.sv
// rabs_pix_if: input pixel channel, valid/ready with the pixel payload
// depends on nothing
`default_nettype none
interface rabs_pix_if;
  logic        valid;
  logic        ready;
  logic [18:0] pixel_index;
  logic [7:0]  sample_c0;
  logic [7:0]  sample_c1;
  logic [7:0]  sample_c2;
  logic        masked;
  logic        hold_update;
  logic        end_of_frame;

  modport source (output valid, pixel_index, sample_c0, sample_c1, sample_c2,
                  masked, hold_update, end_of_frame, input ready);
  modport sink (input valid, pixel_index, sample_c0, sample_c1, sample_c2,
                masked, hold_update, end_of_frame, output ready);
endinterface
`default_nettype wire

### design/rabs_res_if.sv
// rabs_res_if: result channel, valid/ready with the foreground decision
// depends on nothing
`default_nettype none
interface rabs_res_if;
  logic valid;
  logic ready;
  logic foreground;
  logic fg_written;

  modport source (output valid, foreground, fg_written, input ready);
  modport sink (input valid, foreground, fg_written, output ready);
endinterface
`default_nettype wire

### design/rabs_cfg_if.sv
// rabs_cfg_if: configuration write channel, register index and write data
// depends on nothing
`default_nettype none
interface rabs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/running_average_background_subtract_core.sv
// running_average_background_subtract_core: top level, configuration
// registers, frame counter and update pipeline control
// depends on rabs_pkg, the three channel interfaces, rabs_mem, rabs_lane, rabs_merge
//
// Usage: one pixel item enters on pix_i per clock while ready; every item gives
// exactly one result on res_o, in order. Configuration writes arrive on cfg_i, which
// is always ready; write registers only while no item is in flight.
// Path: an item passes the store read, compare, multiply and update stages,
// then the output register, before its result is valid.
// Throughput: one item per clock when not stalled. An item for a pixel still
// held in one of the three update stages waits until that pixel's mean is
// written back, as the mean store has one read and one write port.
// Reset: the model valid store is cleared one pixel a clock, during which
// pix_i.ready is low; the mean store keeps its contents. Config registers
// return to their defaults at once.
// Stall: when res_o is not taken the result waits in the output register and
// up to three more items are still accepted before pix_i.ready drops.
`default_nettype none
module running_average_background_subtract_core import rabs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rabs_pix_if.sink   pix_i,
  rabs_cfg_if.sink   cfg_i,
  rabs_res_if.source res_o
);

  // configuration
  logic [THR_W-1:0]  threshold_q;
  logic [FC_W-1:0]   warmup_q;
  logic [RATE_W-1:0] warm_rate_q, steady_q, close_q;
  logic              cfg_acc;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      warmup_q    <= WARMUP_RST;
      warm_rate_q <= WARM_RATE_RST;
      steady_q    <= STEADY_RST;
      close_q     <= CLOSE_RST;
    end else if (cfg_acc) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgThreshold:    threshold_q <= cfg_i.data[THR_W-1:0];
        CfgWarmupFrames: warmup_q    <= cfg_i.data[FC_W-1:0];
        CfgWarmupRate:   warm_rate_q <= cfg_i.data[RATE_W-1:0];
        CfgSteadyRate:   steady_q    <= cfg_i.data[RATE_W-1:0];
        CfgCloseRate:    close_q     <= cfg_i.data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // input decode
  logic [31:0]       pix32;
  logic [ADDR_W-1:0] in_addr;
  logic              in_live, in_acc, hazard, busy;
  logic [SAMP_W-1:0] samp_in [3];

  assign pix32      = 32'(pix_i.pixel_index);
  assign in_addr    = pix32[ADDR_W-1:0];
  assign in_live    = !pix_i.masked && (pix32 < 32'(NPIX));
  assign samp_in[0] = pix_i.sample_c0;
  assign samp_in[1] = pix_i.sample_c1;
  assign samp_in[2] = pix_i.sample_c2;

  // pipeline occupancy and handshake
  logic v1_q, v2_q, v3_q, v1_d, v2_d, v3_d;
  ctl_t ctl1_q, ctl2_q, ctl3_q;
  logic out_rdy, rdy1, rdy2, rdy3, adv1, adv2, adv3;

  assign adv3 = v3_q && out_rdy;
  assign rdy3 = !v3_q || out_rdy;
  assign adv2 = v2_q && rdy3;
  assign rdy2 = !v2_q || rdy3;
  assign adv1 = v1_q && rdy2;
  assign rdy1 = !v1_q || rdy2;

  // a pixel already on its way to write back must not be read again
  assign hazard = in_live && (
                    (v1_q && ctl1_q.live && (ctl1_q.addr == in_addr)) ||
                    (v2_q && ctl2_q.live && (ctl2_q.addr == in_addr)) ||
                    (v3_q && ctl3_q.live && (ctl3_q.addr == in_addr)));

  assign pix_i.ready = rdy1 && !busy && !hazard;
  assign in_acc      = pix_i.valid && pix_i.ready;

  always_comb begin
    v1_d = v1_q;
    v2_d = v2_q;
    v3_d = v3_q;
    if (in_acc) begin
      v1_d = 1'b1;
    end else if (adv1) begin
      v1_d = 1'b0;
    end
    if (adv1) begin
      v2_d = 1'b1;
    end else if (adv2) begin
      v2_d = 1'b0;
    end
    if (adv2) begin
      v3_d = 1'b1;
    end else if (adv3) begin
      v3_d = 1'b0;
    end
  end

  // frame counter, read for this item then advanced
  logic [FC_W-1:0] fc_q, fc_d;

  always_comb begin
    fc_d = fc_q;
    if (in_acc && pix_i.end_of_frame && (fc_q != FC_MAX)) begin
      fc_d = fc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      fc_q <= '0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      fc_q <= fc_d;
    end
  end

  logic [SAMP_W-1:0]  samp1_q [CHANNELS];
  logic [STORE_W-1:0] mean_rd;
  logic               vld_rd;
  ctl_t               ctl2_d;

  always_comb begin
    ctl2_d       = ctl1_q;
    ctl2_d.first = !vld_rd;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctl1_q.addr  <= in_addr;
      ctl1_q.live  <= in_live;
      ctl1_q.hold  <= pix_i.hold_update;
      ctl1_q.fast  <= fc_q < warmup_q;
      ctl1_q.first <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        samp1_q[k] <= samp_in[k];
      end
    end
    if (adv1) begin
      ctl2_q <= ctl2_d;
    end
    if (adv2) begin
      ctl3_q <= ctl2_q;
    end
  end

  // store
  rd_req_t rd_req;
  wr_req_t wr_req;
  logic [STORE_W-1:0]  new_mean;
  logic [CHANNELS-1:0] over;
  logic [RATE_W-1:0]   fast_rate;

  assign rd_req.en   = in_acc && in_live;
  assign rd_req.addr = in_addr;

  assign wr_req.vld_en  = adv3 && ctl3_q.live;
  assign wr_req.mean_en = adv3 && ctl3_q.live && (ctl3_q.first || !ctl3_q.hold);
  assign wr_req.addr    = ctl3_q.addr;
  assign wr_req.data    = new_mean;

  rabs_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd_req),
    .wr_i      (wr_req),
    .mean_rd_o (mean_rd),
    .vld_rd_o  (vld_rd),
    .busy_o    (busy)
  );

  assign fast_rate = ctl1_q.fast ? warm_rate_q : steady_q;

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    rabs_lane u_lane (
      .clk_i        (clk_i),
      .ld2_i        (adv1),
      .ld3_i        (adv2),
      .mean_i       (mean_rd[k*MEAN_W +: MEAN_W]),
      .sample_i     (samp1_q[k]),
      .thr_i        (threshold_q),
      .fast_rate_i  (fast_rate),
      .close_rate_i (close_q),
      .first_i      (ctl3_q.first),
      .over_o       (over[k]),
      .mean_o       (new_mean[k*MEAN_W +: MEAN_W])
    );
  end

  rabs_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ld_i      (adv3),
    .written_i (ctl3_q.live && !ctl3_q.first),
    .over_i    (over),
    .ready_o   (out_rdy),
    .res_o     (res_o)
  );

`ifndef ASSERT_OFF
  a_stage3_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !out_rdy) |=> (v3_q && $stable(ctl3_q)))
    else $error("update stage lost its item under stall");
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q)
    else $error("accepted item did not enter the pipeline");
  a_fc_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fc_q == FC_MAX) |=> (fc_q == FC_MAX))
    else $error("frame counter wrapped");
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("clearing pass restarted");
`endif

endmodule
`default_nettype wire

### design/rabs_mem.sv
// rabs_mem: per-pixel mean store and model valid store with its clearing pass
// depends on rabs_pkg
`default_nettype none
module rabs_mem import rabs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rd_req_t            rd_i,
  input  wire wr_req_t            wr_i,
  output logic [STORE_W-1:0]      mean_rd_o,
  output logic                    vld_rd_o,
  output logic                    busy_o
);

  logic [STORE_W-1:0] mean_mem [NPIX];
  logic               vld_mem  [NPIX];

  logic              busy_q, busy_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  always_comb begin
    busy_d = busy_q;
    clr_d  = clr_q;
    if (busy_q) begin
      if (clr_q == ADDR_W'(NPIX - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_d = clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      vld_mem[clr_q] <= 1'b0;
    end else if (wr_i.vld_en) begin
      vld_mem[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.mean_en) begin
      mean_mem[wr_i.addr] <= wr_i.data;
    end
  end

  // read before write at a shared edge; the top keeps such pairs apart
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      mean_rd_o <= mean_mem[rd_i.addr];
      vld_rd_o  <= vld_mem[rd_i.addr];
    end
  end

  assign busy_o = busy_q;

endmodule
`default_nettype wire

### design/rabs_lane.sv
// rabs_lane: one colour channel of the update datapath, compare, multiply
// and move the mean toward the sample; depends on rabs_pkg
`default_nettype none
module rabs_lane import rabs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              ld2_i,
  input  wire logic              ld3_i,
  input  wire logic [MEAN_W-1:0] mean_i,
  input  wire logic [SAMP_W-1:0] sample_i,
  input  wire logic [THR_W-1:0]  thr_i,
  input  wire logic [RATE_W-1:0] fast_rate_i,
  input  wire logic [RATE_W-1:0] close_rate_i,
  input  wire logic              first_i,
  output logic                   over_o,
  output logic [MEAN_W-1:0]      mean_o
);

  logic [MEAN_W-1:0] s_full, dif, thr_full;
  logic              up, over;
  logic [RATE_W-1:0] rate;

  logic [MEAN_W-1:0] dif2_q, m2_q, m3_q;
  logic [SAMP_W-1:0] s2_q, s3_q;
  logic [RATE_W-1:0] rate2_q;
  logic              up2_q, up3_q, over2_q, over3_q;
  logic [PROD_W-1:0] prod3_q;
  logic [MEAN_W-1:0] delta;

  assign s_full   = {sample_i, FRAC_W'(0)};
  assign thr_full = {thr_i, FRAC_W'(0)};
  assign up       = s_full >= mean_i;
  assign dif      = up ? (s_full - mean_i) : (mean_i - s_full);
  assign over     = dif > thr_full;
  assign rate     = over ? fast_rate_i : close_rate_i;

  always_ff @(posedge clk_i) begin
    if (ld2_i) begin
      dif2_q  <= dif;
      rate2_q <= rate;
      up2_q   <= up;
      m2_q    <= mean_i;
      s2_q    <= sample_i;
      over2_q <= over;
    end
  end

  // rounding half folded into the product register
  always_ff @(posedge clk_i) begin
    if (ld3_i) begin
      prod3_q <= PROD_W'(dif2_q) * PROD_W'(rate2_q) + ROUND_HALF;
      up3_q   <= up2_q;
      m3_q    <= m2_q;
      s3_q    <= s2_q;
      over3_q <= over2_q;
    end
  end

  assign delta  = prod3_q[FRAC_W +: MEAN_W];
  assign over_o = over3_q;

  always_comb begin
    if (first_i) begin
      mean_o = {s3_q, FRAC_W'(0)};
    end else if (up3_q) begin
      mean_o = m3_q + delta;
    end else begin
      mean_o = m3_q - delta;
    end
  end

endmodule
`default_nettype wire

### design/rabs_merge.sv
// rabs_merge: combines the lane decisions into one result and holds it in
// the output register; depends on rabs_pkg and rabs_res_if
`default_nettype none
module rabs_merge import rabs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                ld_i,
  input  wire logic                written_i,
  input  wire logic [CHANNELS-1:0] over_i,
  output logic                     ready_o,
  rabs_res_if.source               res_o
);

  logic out_v_q, out_v_d;
  logic fg_q, wr_q;

  assign ready_o = !out_v_q || res_o.ready;

  always_comb begin
    out_v_d = out_v_q;
    if (ld_i) begin
      out_v_d = 1'b1;
    end else if (res_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      fg_q <= written_i && (|over_i);
      wr_q <= written_i;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.foreground = fg_q;
  assign res_o.fg_written = wr_q;

endmodule
`default_nettype wire

### sim/testbench.sv
// testbench for running_average_background_subtract_core: a directed table, then random
// pixel streams over several register settings, checked against a behavioural predictor
// depends on rabs_pkg, rabs_pix_if, rabs_cfg_if, rabs_res_if and the core itself
`timescale 1ns / 1ps
module testbench;
  import rabs_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned LIMIT_CYCLES = 1_200_000;
  localparam int unsigned POOL_SIZE    = 48;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 172;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLDOFF_LEN  = 400;

  typedef struct packed {
    logic [18:0]     pixel_index;
    logic [2:0][7:0] sample;
    logic            masked;
    logic            hold;
    logic            eof;
  } pixel_t;

  typedef struct packed {
    logic foreground;
    logic fg_written;
  } decision_t;

  typedef struct packed {
    logic [7:0]  thr;
    logic [3:0]  warm_frames;
    logic [15:0] warm_rate;
    logic [15:0] steady_rate;
    logic [15:0] close_rate;
  } bg_cfg_t;

  typedef struct {
    pixel_t    px;
    bit        typed;
    decision_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rabs_pix_if pix_bus ();
  rabs_cfg_if cfg_bus ();
  rabs_res_if res_bus ();

  running_average_background_subtract_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_bus),
    .cfg_i  (cfg_bus),
    .res_o  (res_bus)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // predictor state
  logic [23:0] bg_mean [int unsigned];
  bit          pix_seen [int unsigned];
  logic [3:0]  frame_cnt;
  bg_cfg_t     cfg_now;

  decision_t   decisions_due [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned stall_left = 0;
  bit          stall_req = 1'b0;
  int unsigned pix_pool [POOL_SIZE];

  function automatic decision_t classify_pixel(pixel_t px);
    decision_t   d;
    logic [23:0] m, s, dif, step;
    logic [40:0] prod;
    logic [15:0] fast, rate;
    logic        over;
    int unsigned key;
    int          k;
    d = '0;
    if (!px.masked && px.pixel_index < NPIX) begin
      if (!pix_seen.exists(px.pixel_index)) begin
        for (k = 0; k < CHANNELS; k++) begin
          bg_mean[px.pixel_index * CHANNELS + k] = {px.sample[k], 16'h0000};
        end
        pix_seen[px.pixel_index] = 1'b1;
      end else begin
        fast = (frame_cnt < cfg_now.warm_frames) ? cfg_now.warm_rate : cfg_now.steady_rate;
        d.fg_written = 1'b1;
        for (k = 0; k < CHANNELS; k++) begin
          key = px.pixel_index * CHANNELS + k;
          m = bg_mean[key];
          s = {px.sample[k], 16'h0000};
          dif = (m >= s) ? m - s : s - m;
          over = dif > {cfg_now.thr, 16'h0000};
          if (over) d.foreground = 1'b1;
          rate = over ? fast : cfg_now.close_rate;
          prod = 41'(dif) * 41'(rate);
          step = 24'((prod + 41'd32768) >> 16);
          if (!px.hold) bg_mean[key] = (s >= m) ? m + step : m - step;
        end
      end
    end
    // counter is read for this pixel first, then advanced
    if (px.eof && frame_cnt != 4'hF) frame_cnt++;
    return d;
  endfunction

  function automatic stim_row_t make_row(int unsigned p, logic [7:0] c0, logic [7:0] c1,
                                         logic [7:0] c2, bit m, bit h, bit e,
                                         bit typed, bit fg, bit wr);
    stim_row_t r;
    r.px.pixel_index = p[18:0];
    r.px.sample[0] = c0;
    r.px.sample[1] = c1;
    r.px.sample[2] = c2;
    r.px.masked = m;
    r.px.hold = h;
    r.px.eof = e;
    r.typed = typed;
    r.want.foreground = fg;
    r.want.fg_written = wr;
    return r;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t      px;
    int unsigned pick, span;
    int          v, k;
    pick = $urandom_range(99);
    if (pick < 82) px.pixel_index = 19'(pix_pool[$urandom_range(POOL_SIZE - 1)]);
    else if (pick < 92) px.pixel_index = 19'($urandom_range(NPIX - 1));
    else px.pixel_index = 19'($urandom_range(19'h7FFFF, NPIX));
    span = (cfg_now.thr > 250) ? 255 : cfg_now.thr + 3;
    for (k = 0; k < 3; k++) begin
      // mostly close to the learnt mean so both sides of the threshold get hit
      if (pix_seen.exists(px.pixel_index) && k < CHANNELS && $urandom_range(99) < 60) begin
        v = int'(bg_mean[px.pixel_index * CHANNELS + k][23:16]) +
            int'($urandom_range(2 * span)) - int'(span);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        px.sample[k] = v[7:0];
      end else begin
        px.sample[k] = 8'($urandom_range(255));
      end
    end
    px.masked = $urandom_range(99) < 7;
    px.hold = $urandom_range(99) < 12;
    px.eof = $urandom_range(79) == 0;
    return px;
  endfunction

  task automatic send_pixel(pixel_t px, bit typed, decision_t want);
    decision_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_bus.valid        <= 1'b1;
    pix_bus.pixel_index  <= px.pixel_index;
    pix_bus.sample_c0    <= px.sample[0];
    pix_bus.sample_c1    <= px.sample[1];
    pix_bus.sample_c2    <= px.sample[2];
    pix_bus.masked       <= px.masked;
    pix_bus.hold_update  <= px.hold;
    pix_bus.end_of_frame <= px.eof;
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
    pred = classify_pixel(px);
    decisions_due.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic apply_config(bg_cfg_t c);
    write_reg(CfgThreshold, {8'h00, c.thr});
    write_reg(CfgWarmupFrames, {12'h000, c.warm_frames});
    write_reg(CfgWarmupRate, c.warm_rate);
    write_reg(CfgSteadyRate, c.steady_rate);
    write_reg(CfgCloseRate, c.close_rate);
    cfg_bus.valid <= 1'b0;
    cfg_now = c;
  endtask

  task automatic drain_pipeline();
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: check each item, then pick ready for the next edge
  always @(posedge clk) begin
    decision_t want;
    if (res_bus.valid && res_bus.ready) begin
      if (decisions_due.size() == 0) begin
        $display("%0t: result with none pending, got foreground %0b fg_written %0b",
                 $time, res_bus.foreground, res_bus.fg_written);
        mismatches++;
      end else begin
        want = decisions_due.pop_front();
        if (res_bus.foreground !== want.foreground) begin
          $display("%0t: foreground expected %0b got %0b",
                   $time, want.foreground, res_bus.foreground);
          mismatches++;
        end
        if (res_bus.fg_written !== want.fg_written) begin
          $display("%0t: fg_written expected %0b got %0b",
                   $time, want.fg_written, res_bus.fg_written);
          mismatches++;
        end
      end
    end
    if (stall_req) begin
      stall_req = 1'b0;
      stall_left = HOLDOFF_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin : stimulus
    stim_row_t   rows [$];
    bg_cfg_t     phase_cfg [PHASES];
    int unsigned send_pct [PHASES];
    int unsigned rx_pct [PHASES];
    int          ph, n;

    rst_n = 1'b0;
    pix_bus.valid = 1'b0;
    pix_bus.pixel_index = '0;
    pix_bus.sample_c0 = '0;
    pix_bus.sample_c1 = '0;
    pix_bus.sample_c2 = '0;
    pix_bus.masked = 1'b0;
    pix_bus.hold_update = 1'b0;
    pix_bus.end_of_frame = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CfgThreshold;
    cfg_bus.data = '0;
    res_bus.ready = 1'b0;

    frame_cnt = '0;
    cfg_now = '{thr: 8'd30, warm_frames: 4'd10, warm_rate: 16'd32768,
                steady_rate: 16'd3, close_rate: 16'd3277};

    // first visits, out of range and masked pixels give no decision; then pixel 0 is revisited
    rows.push_back(make_row(0,      8'h00, 8'h00, 8'h00, 0, 0, 0, 1, 0, 0));
    rows.push_back(make_row(307199, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 1, 0, 0));
    rows.push_back(make_row(307200, 8'hAA, 8'h55, 8'hFF, 0, 0, 0, 1, 0, 0));
    rows.push_back(make_row(524287, 8'h55, 8'hAA, 8'h00, 0, 0, 0, 1, 0, 0));
    rows.push_back(make_row(5,      8'h09, 8'h09, 8'h09, 1, 0, 0, 1, 0, 0));
    rows.push_back(make_row(0,      8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 1, 1, 1));
    rows.push_back(make_row(0,      8'd128, 8'd128, 8'd128, 0, 0, 0, 0, 0, 0));
    // held pixel: exactly at threshold, then one over on each channel
    rows.push_back(make_row(307199, 8'd255, 8'd255, 8'd255, 0, 1, 0, 1, 0, 1));
    rows.push_back(make_row(307199, 8'd225, 8'd225, 8'd225, 0, 1, 0, 1, 0, 1));
    rows.push_back(make_row(307199, 8'd224, 8'd255, 8'd255, 0, 1, 0, 1, 1, 1));
    rows.push_back(make_row(307199, 8'd255, 8'd224, 8'd255, 0, 1, 0, 1, 1, 1));
    rows.push_back(make_row(307199, 8'd255, 8'd255, 8'd224, 0, 1, 0, 1, 1, 1));
    rows.push_back(make_row(307199, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
    rows.push_back(make_row(307199, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
    // end of frame on a masked pixel and on a first visit
    rows.push_back(make_row(5,      8'h00, 8'h00, 8'h00, 1, 0, 1, 1, 0, 0));
    rows.push_back(make_row(5,      8'd170, 8'd85, 8'd0, 0, 0, 1, 1, 0, 0));
    rows.push_back(make_row(5,      8'd85, 8'd170, 8'd255, 0, 0, 0, 0, 0, 0));
    rows.push_back(make_row(5,      8'd85, 8'd170, 8'd255, 0, 1, 0, 0, 0, 0));
    rows.push_back(make_row(174762, 8'h55, 8'h55, 8'h55, 0, 0, 0, 1, 0, 0));
    rows.push_back(make_row(174762, 8'hAA, 8'hAA, 8'hAA, 0, 0, 0, 0, 0, 0));
    rows.push_back(make_row(349525, 8'h11, 8'h22, 8'h33, 0, 0, 1, 1, 0, 0));
    rows.push_back(make_row(0,      8'h00, 8'h00, 8'h00, 1, 1, 1, 1, 0, 0));
    rows.push_back(make_row(0,      8'd128, 8'd127, 8'd129, 0, 0, 0, 0, 0, 0));

    phase_cfg[0] = '{thr: 8'd0, warm_frames: 4'd15, warm_rate: 16'hFFFF,
                     steady_rate: 16'd0, close_rate: 16'hFFFF};
    phase_cfg[1] = '{thr: 8'd255, warm_frames: 4'd0, warm_rate: 16'd0,
                     steady_rate: 16'hFFFF, close_rate: 16'd0};
    phase_cfg[2] = '{thr: 8'd30, warm_frames: 4'd10, warm_rate: 16'd32768,
                     steady_rate: 16'd3, close_rate: 16'd3277};
    phase_cfg[3] = '{thr: 8'd12, warm_frames: 4'd15, warm_rate: 16'd40000,
                     steady_rate: 16'd200, close_rate: 16'd1500};
    for (ph = 4; ph < PHASES; ph++) begin
      phase_cfg[ph].thr = 8'($urandom_range(60));
      phase_cfg[ph].warm_frames = 4'($urandom_range(15));
      phase_cfg[ph].warm_rate = 16'($urandom_range(16'hFFFF));
      phase_cfg[ph].steady_rate = 16'($urandom_range(16'hFFFF));
      phase_cfg[ph].close_rate = 16'($urandom_range(16'hFFFF));
    end
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_pct[ph] = 0;  rx_pct[ph] = 0;  end
        1: begin send_pct[ph] = 50; rx_pct[ph] = 0;  end
        2: begin send_pct[ph] = 0;  rx_pct[ph] = 50; end
        default: begin send_pct[ph] = 24; rx_pct[ph] = 24; end
      endcase
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, then a clean pipeline before any register write
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].typed, rows[i].want);
    pix_bus.valid <= 1'b0;
    drain_pipeline();

    foreach (pix_pool[i]) begin
      pix_pool[i] = (i == 0) ? NPIX - 1 : $urandom_range(NPIX - 1);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      apply_config(phase_cfg[ph]);
      send_idle_pct = send_pct[ph];
      rx_stall_pct = rx_pct[ph];
      // long hold-off on the result side so the pipeline backs up into pix_i
      if (ph == 4) stall_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) send_pixel(random_pixel(), 1'b0, '0);
      pix_bus.valid <= 1'b0;
      drain_pipeline();
    end

    if (mismatches == 0) begin
      $display("running_average_background_subtract_core: match");
    end else begin
      $display("running_average_background_subtract_core: mismatch");
    end
    $finish;
  end

  // a timeout that leaves room for the clearing pass after reset
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("running_average_background_subtract_core: mismatch");
    $finish;
  end

endmodule

### sim.f
design/rabs_pkg.sv
design/rabs_pix_if.sv
design/rabs_res_if.sv
design/rabs_cfg_if.sv
design/rabs_mem.sv
design/rabs_lane.sv
design/rabs_merge.sv
design/running_average_background_subtract_core.sv
sim/testbench.sv
